### design/c8x_pkg.sv
// Package with the shared types, opcodes and state codes of the CHIP-8 execute unit.
`default_nettype none
package c8x_pkg;

  // Operation codes carried in the kind field.
  typedef enum logic [5:0] {
    OP_NOP = 6'd0, OP_CLS = 6'd1, OP_RET = 6'd2, OP_JP = 6'd3, OP_CALL = 6'd4,
    OP_SE_KK = 6'd5, OP_SNE_KK = 6'd6, OP_SE_XY = 6'd7, OP_LD_KK = 6'd8,
    OP_ADD_KK = 6'd9, OP_LD_XY = 6'd10, OP_OR = 6'd11, OP_AND = 6'd12,
    OP_XOR = 6'd13, OP_ADD_XY = 6'd14, OP_SUB = 6'd15, OP_SHR = 6'd16,
    OP_SUBN = 6'd17, OP_SHL = 6'd18, OP_SNE_XY = 6'd19, OP_LD_I = 6'd20,
    OP_JP_V0 = 6'd21, OP_RND = 6'd22, OP_DRW = 6'd23, OP_SKP = 6'd24,
    OP_SKNP = 6'd25, OP_LD_DT = 6'd26, OP_LD_K = 6'd27, OP_SET_DT = 6'd28,
    OP_SET_ST = 6'd29, OP_ADD_I = 6'd30, OP_LD_F = 6'd31, OP_BCD = 6'd32,
    OP_STORE = 6'd33, OP_LOAD = 6'd34, OP_HOST_WR = 6'd35
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_LOOP, ST_WAIT, ST_CLEAR, ST_DONE
  } state_t;

  // One input word.
  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] instr;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
    logic [7:0]  delay_now;
    logic [11:0] load_addr;
    logic [7:0]  load_data;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [11:0] pc_value;
    logic        redraw;
    logic        delay_set;
    logic [7:0]  delay_value;
    logic        sound_set;
    logic [7:0]  sound_value;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input word
    logic exec;     // perform operations that need no loop
    logic loop_rd;  // issue memory read and write for loop step
    logic loop_wr;  // consume read data / update registers for loop step
    logic clr_row;  // clear one display row
    logic finish;   // final register updates
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic multi;     // operation needs the loop
    logic is_cls;
    logic last_step; // current loop step is the last one
  } dp_stat_t;

  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;

endpackage
`default_nettype wire

### design/c8x_ctrl.sv
// Controller state machine that sequences one operation through the datapath.
`default_nettype none
module c8x_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  input  c8x_pkg::dp_stat_t   stat,
  output c8x_pkg::dp_cmd_t    cmd
);
  import c8x_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.is_cls) state_next = ST_CLEAR;
        else if (stat.multi) begin
          cmd.loop_rd = 1'b1;
          state_next = ST_LOOP;
        end else begin
          cmd.exec = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_LOOP: begin
        cmd.loop_wr = 1'b1;
        if (stat.last_step) begin
          cmd.finish = 1'b1;
          state_next = ST_DONE;
        end else state_next = ST_WAIT;
      end
      ST_WAIT: begin
        cmd.loop_rd = 1'b1;
        state_next = ST_LOOP;
      end
      ST_CLEAR: begin
        cmd.clr_row = 1'b1;
        if (stat.last_step) state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_load_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_EXEC) else $error("load not followed by exec");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

### design/c8x_datapath.sv
// Datapath: registers, stack, memory, display and result of the execute unit.
`default_nettype none
module c8x_datapath #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 legacy_quirks,
  input  c8x_pkg::in_word_t   in_word,
  input  c8x_pkg::dp_cmd_t    cmd,
  output c8x_pkg::dp_stat_t   stat,
  output c8x_pkg::out_word_t  out_word
);
  import c8x_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int SW = $clog2(STACK_DEPTH);

  in_word_t        cur;
  logic [7:0]      gp_regs [16];
  logic [11:0]     index_reg;
  logic [11:0]     prog_counter;
  logic [SW-1:0]   stack_ptr;
  logic [11:0]     return_stack [STACK_DEPTH];
  logic [7:0]      main_memory [MEM_BYTES];
  logic [63:0]     frame_rows [SCREEN_H];
  logic [7:0]      mem_rd;
  logic [4:0]      step;
  logic            hit;
  logic            redraw, dset, sset;
  logic [7:0]      dval, sval;

  op_t         op;
  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy, vsrc;
  logic [11:0] nnn;
  logic [8:0]  sum;
  logic [3:0]  hi_key;
  logic [11:0] addr;
  logic [AW-1:0] maddr;
  logic [5:0]  x0;
  logic [4:0]  y0;
  logic [5:0]  row_idx;
  logic [7:0]  spr_rev;
  logic [70:0] spr_wide;
  logic [63:0] spr_mask;
  logic [7:0]  bcd_h, bcd_t, bcd_o, bcd_rem;
  logic [7:0]  wr_byte;
  logic        mem_we;
  logic [4:0]  nsteps;

  assign op  = op_t'(cur.kind);
  assign x   = cur.instr[11:8];
  assign y   = cur.instr[7:4];
  assign n   = cur.instr[3:0];
  assign kk  = cur.instr[7:0];
  assign nnn = cur.instr[11:0];
  assign vx  = gp_regs[x];
  assign vy  = gp_regs[y];
  assign vsrc = legacy_quirks ? vy : vx;
  assign sum = {1'b0, vx} + {1'b0, vy};
  assign x0 = vx[5:0];
  assign y0 = vy[4:0];
  assign row_idx = {1'b0, y0} + {1'b0, step};

  // Highest pressed key.
  always_comb begin
    hi_key = '0;
    for (int k = 0; k < 16; k++) if (cur.key_mask[k]) hi_key = 4'(k);
  end

  // Digits of Vx by subtraction compares.
  always_comb begin
    bcd_h = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
    bcd_rem = vx - 8'(bcd_h * 8'd100);
    bcd_t = '0;
    for (int d = 1; d < 10; d++) if (bcd_rem >= 8'(d * 10)) bcd_t = 8'(d);
    bcd_o = bcd_rem - 8'(bcd_t * 8'd10);
  end

  // Number of loop steps for the operation.
  always_comb begin
    case (op)
      OP_BCD:   nsteps = 5'd3;
      OP_STORE, OP_LOAD: nsteps = {1'b0, x} + 5'd1;
      OP_DRW:   nsteps = (n == 4'd0) ? 5'd1 : {1'b0, n};
      OP_HOST_WR: nsteps = 5'd1;
      OP_CLS:   nsteps = 5'(SCREEN_H);
      default:  nsteps = 5'd1;
    endcase
  end

  assign stat.multi = (op == OP_BCD) || (op == OP_STORE) || (op == OP_LOAD) ||
                      ((op == OP_DRW) && (n != 4'd0)) || (op == OP_HOST_WR);
  assign stat.is_cls = (op == OP_CLS);
  assign stat.last_step = (step == nsteps - 5'd1);

  // Memory address for the current loop step.
  assign addr  = (op == OP_HOST_WR) ? cur.load_addr : index_reg + 12'(step);
  assign maddr = AW'(addr);

  // Byte written in a loop step.
  always_comb begin
    mem_we = 1'b0;
    wr_byte = gp_regs[step[3:0]];
    case (op)
      OP_BCD: begin
        mem_we = 1'b1;
        wr_byte = (step == 5'd0) ? bcd_h : (step == 5'd1) ? bcd_t : bcd_o;
      end
      OP_STORE: mem_we = 1'b1;
      OP_HOST_WR: begin
        mem_we = 1'b1;
        wr_byte = cur.load_data;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Main memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.loop_rd && mem_we) main_memory[maddr] <= wr_byte;
    mem_rd <= main_memory[maddr];
  end

  // Sprite row aligned to the display, clipped at the right edge.
  // The leftmost pixel is the top bit of the byte and lands on column x0.
  always_comb begin
    for (int b = 0; b < 8; b++) spr_rev[b] = mem_rd[7-b];
  end
  assign spr_wide = {63'd0, spr_rev} << x0;
  assign spr_mask = spr_wide[63:0];

  // Loop step counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.load) step <= '0;
    else if (cmd.loop_wr || cmd.clr_row) step <= step + 5'd1;
  end

  // Main register and display updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 16; r++) gp_regs[r] <= '0;
      for (int r = 0; r < SCREEN_H; r++) frame_rows[r] <= '0;
      index_reg <= '0;
      prog_counter <= '0;
      stack_ptr <= '0;
      hit <= 1'b0;
      redraw <= 1'b0;
      dset <= 1'b0;
      sset <= 1'b0;
      dval <= '0;
      sval <= '0;
    end else begin
      if (cmd.load) begin
        cur <= in_word;
        hit <= 1'b0;
        redraw <= 1'b0;
        dset <= 1'b0;
        sset <= 1'b0;
        dval <= '0;
        sval <= '0;
      end
      if (cmd.clr_row) begin
        frame_rows[step] <= '0;
        redraw <= 1'b1;
      end
      if (cmd.loop_wr) begin
        if (op == OP_LOAD) gp_regs[step[3:0]] <= mem_rd;
        if (op == OP_DRW && !row_idx[5]) begin
          frame_rows[row_idx[4:0]] <= frame_rows[row_idx[4:0]] ^ spr_mask;
          if ((frame_rows[row_idx[4:0]] & spr_mask) != '0) hit <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if ((op == OP_STORE || op == OP_LOAD) && legacy_quirks)
          index_reg <= index_reg + {8'd0, x} + 12'd1;
        if (op == OP_DRW) begin
          gp_regs[15] <= {7'd0, hit ||
            (!row_idx[5] && (frame_rows[row_idx[4:0]] & spr_mask) != '0)};
          redraw <= 1'b1;
        end
      end
      if (cmd.exec) begin
        case (op)
          OP_RET: begin
            prog_counter <= return_stack[stack_ptr - SW'(1)];
            stack_ptr <= stack_ptr - SW'(1);
          end
          OP_JP: prog_counter <= nnn;
          OP_CALL: begin
            return_stack[stack_ptr] <= prog_counter;
            prog_counter <= nnn;
            stack_ptr <= stack_ptr + SW'(1);
          end
          OP_SE_KK:  if (vx == kk) prog_counter <= prog_counter + 12'd2;
          OP_SNE_KK: if (vx != kk) prog_counter <= prog_counter + 12'd2;
          OP_SE_XY:  if (vx == vy) prog_counter <= prog_counter + 12'd2;
          OP_SNE_XY: if (vx != vy) prog_counter <= prog_counter + 12'd2;
          OP_LD_KK:  gp_regs[x] <= kk;
          OP_ADD_KK: gp_regs[x] <= vx + kk;
          OP_LD_XY:  gp_regs[x] <= vy;
          OP_OR:     gp_regs[x] <= vx | vy;
          OP_AND:    gp_regs[x] <= vx & vy;
          OP_XOR:    gp_regs[x] <= vx ^ vy;
          OP_ADD_XY: begin
            gp_regs[x] <= sum[7:0];
            gp_regs[15] <= {7'd0, sum[8]};
          end
          OP_SUB: begin
            gp_regs[x] <= vx - vy;
            gp_regs[15] <= {7'd0, vx >= vy};
          end
          OP_SUBN: begin
            gp_regs[x] <= vy - vx;
            gp_regs[15] <= {7'd0, vy >= vx};
          end
          OP_SHR: begin
            gp_regs[x] <= {1'b0, vsrc[7:1]};
            gp_regs[15] <= {7'd0, vsrc[0]};
          end
          OP_SHL: begin
            gp_regs[x] <= {vsrc[6:0], 1'b0};
            gp_regs[15] <= {7'd0, vsrc[7]};
          end
          OP_LD_I:   index_reg <= nnn;
          OP_JP_V0:  prog_counter <= {4'd0, gp_regs[0]} + nnn;
          OP_RND:    gp_regs[x] <= cur.random_byte & kk;
          OP_DRW: begin
            gp_regs[15] <= '0;
            redraw <= 1'b1;
          end
          OP_SKP: if (vx < 8'd16 && cur.key_mask[vx[3:0]])
            prog_counter <= prog_counter + 12'd2;
          OP_SKNP: if (!(vx < 8'd16 && cur.key_mask[vx[3:0]]))
            prog_counter <= prog_counter + 12'd2;
          OP_LD_DT:  gp_regs[x] <= cur.delay_now;
          OP_LD_K: begin
            if (cur.key_mask == '0) prog_counter <= prog_counter - 12'd2;
            else gp_regs[x] <= {4'd0, hi_key};
          end
          OP_SET_DT: begin
            dset <= 1'b1;
            dval <= vx;
          end
          OP_SET_ST: begin
            sset <= 1'b1;
            sval <= vx;
          end
          OP_ADD_I:  index_reg <= index_reg + {4'd0, vx};
          OP_LD_F:   index_reg <= {4'd0, vx} * 12'd5;
          default: ;
        endcase
      end
    end
  end

  assign out_word.pc_value    = prog_counter;
  assign out_word.redraw      = redraw;
  assign out_word.delay_set   = dset;
  assign out_word.delay_value = dval;
  assign out_word.sound_set   = sset;
  assign out_word.sound_value = sval;

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.loop_wr |-> step < 5'd16) else $error("loop step past sixteen");
  a_flag_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !redraw && !dset && !sset) else $error("stale result flags");
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.exec, cmd.loop_rd, cmd.clr_row}))
    else $error("overlapping commands");
`endif
endmodule
`default_nettype wire

### design/chip8_instruction_execute_top.sv
// Top level of the CHIP-8 execute unit: controller, datapath and quirk register.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------
//  input    | in_valid / in_ready     | in_data  (in_word_t)
//  output   | out_valid / out_ready   | out_data (out_word_t)
//  config   | cfg_we                  | cfg_data (legacy_quirks)
//
// Simple operations pass from EXEC to DONE and then wait for the output; memory
// operations take a LOOP state per accessed byte, with a WAIT state between bytes
// (single-port memory read then register update), as a draw of n rows or a block
// move of x+1 bytes. CLS clears one display row per cycle, all 32 rows. Reset is
// synchronous; memory and return stack are not cleared. The next word is taken
// only after the result has been accepted.
`default_nettype none
module chip8_instruction_execute_top #(
  parameter int MEM_BYTES   = 4096,
  parameter int STACK_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  c8x_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output c8x_pkg::out_word_t  out_data,
  input  wire                 cfg_we,
  input  wire                 cfg_data
);
  import c8x_pkg::*;

  logic     legacy_quirks;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Quirk mode register.
  always_ff @(posedge clk) begin
    if (rst) legacy_quirks <= 1'b0;
    else if (cfg_we) legacy_quirks <= cfg_data;
  end

  c8x_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  c8x_datapath #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .legacy_quirks(legacy_quirks), .in_word(in_data),
    .cmd(cmd), .stat(stat), .out_word(out_data)
  );

endmodule
`default_nettype wire
